FILE: hw/rtl/bfth_pkg.sv
// ----------------------------------------------------------------------------
// bfth_pkg
// Shared types and constants for the three-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfth_pkg;

    // The filter size must be a power of two. The hash reduction then keeps
    // the low index bits.
    localparam int FILTER_BITS = 8192;
    localparam int NUM_HASHES  = 3;

    localparam int IDX_W  = $clog2(FILTER_BITS);
    localparam int WORD_W = (FILTER_BITS < 32) ? FILTER_BITS : 32;
    localparam int OFS_W  = $clog2(WORD_W);
    localparam int ROWS   = FILTER_BITS / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int K_W    = 2;

    localparam logic [31:0] DJB_START = 32'd5381;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_CHECK = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [31:0] djb;
        logic [31:0] sdbm;
        logic [31:0] sum;
    } t_hash_set;

    typedef struct packed {
        logic fold;
        logic restart;
    } t_hash_ctrl;

    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [ROW_W-1:0]  raddr;
    } t_mem_req;

endpackage

FILE: hw/rtl/bfth_ram.sv
// ----------------------------------------------------------------------------
// bfth_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/bfth_hash.sv
// ----------------------------------------------------------------------------
// bfth_hash
// Hash accumulators: djb2, sdbm and byte sum, one character per cycle while fold is set.
// ----------------------------------------------------------------------------
module bfth_hash (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfth_pkg::t_hash_ctrl  i_ctrl,
    input  logic [7:0]            i_char,
    output bfth_pkg::t_hash_set   o_folded
);
    import bfth_pkg::*;

    logic [31:0] r_djb, r_sdbm, r_sum;
    logic [31:0] n_djb, n_sdbm, n_sum;
    logic [31:0] c_ext;

    // A zero character leaves the hashes as they stand.
    always_comb begin
        c_ext  = {{24{i_char[7]}}, i_char};
        n_djb  = r_djb;
        n_sdbm = r_sdbm;
        n_sum  = r_sum;
        if (i_char != 8'd0) begin
            n_djb  = (r_djb << 5) + r_djb + c_ext;
            n_sdbm = c_ext + (r_sdbm << 6) + (r_sdbm << 16) - r_sdbm;
            n_sum  = r_sum + c_ext;
        end
    end

    assign o_folded = '{djb: n_djb, sdbm: n_sdbm, sum: n_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.restart) begin
            r_djb  <= DJB_START;
            r_sdbm <= '0;
            r_sum  <= '0;
        end else if (i_ctrl.fold) begin
            r_djb  <= n_djb;
            r_sdbm <= n_sdbm;
            r_sum  <= n_sum;
        end
    end

endmodule

FILE: hw/rtl/bfth_ctrl.sv
// ----------------------------------------------------------------------------
// bfth_ctrl
// Sequencer: input handshake, store clearing sweep, per-index read-modify-write
// and the check result register.
// ----------------------------------------------------------------------------
module bfth_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic                          i_last,
    input  bfth_pkg::t_hash_set           i_folded,
    output bfth_pkg::t_hash_ctrl          o_hash_ctrl,
    output bfth_pkg::t_mem_req            o_mem_req,
    input  logic [bfth_pkg::WORD_W-1:0]   i_mem_rdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_maybe_present
);
    import bfth_pkg::*;

    t_state            r_state, n_state;
    logic [ROW_W-1:0]  r_clr_row, n_clr_row;
    logic [K_W-1:0]    r_k, n_k;
    logic [IDX_W-1:0]  r_idx [3];
    logic [IDX_W-1:0]  n_idx [3];
    logic              r_check, n_check;
    logic              r_all, n_all;
    logic              r_out_valid, n_out_valid;
    logic              r_out_data, n_out_data;

    t_cmd              cmd;
    logic              accept;
    logic              key_cmd;
    logic              k_last;
    logic              clr_done;
    logic [IDX_W-1:0]  cur_idx;
    logic [ROW_W-1:0]  cur_row;
    logic [OFS_W-1:0]  cur_ofs;
    logic              cur_bit;

    assign cmd        = t_cmd'(i_command);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign key_cmd    = (cmd == CMD_ADD) || (cmd == CMD_CHECK);
    assign k_last     = (r_k == K_W'(NUM_HASHES - 1));
    assign clr_done   = (r_clr_row == ROW_W'(ROWS - 1));

    always_comb begin
        unique case (r_k)
            2'd0:    cur_idx = r_idx[0];
            2'd1:    cur_idx = r_idx[1];
            default: cur_idx = r_idx[2];
        endcase
    end

    assign cur_row = ROW_W'(cur_idx >> OFS_W);
    assign cur_ofs = cur_idx[OFS_W-1:0];
    assign cur_bit = i_mem_rdata[cur_ofs];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd) inside
                        CMD_ADD, CMD_CHECK: begin
                            if (i_last) begin
                                n_state = S_READ;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_UPDATE;
            S_UPDATE: begin
                if (!k_last) begin
                    n_state = S_READ;
                end else if (r_check) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        n_clr_row   = r_clr_row;
        n_k         = r_k;
        n_idx       = r_idx;
        n_check     = r_check;
        n_all       = r_all;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        o_hash_ctrl.fold    = accept && key_cmd;
        o_hash_ctrl.restart = accept && ((cmd == CMD_CLEAR) || (key_cmd && i_last));

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = cur_row;
        o_mem_req.wdata = i_mem_rdata | (WORD_W'(1) << cur_ofs);
        o_mem_req.raddr = cur_row;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr_row;
                o_mem_req.wdata = '0;
                n_clr_row       = r_clr_row + ROW_W'(1);
            end
            S_IDLE: begin
                n_clr_row = '0;
                if (accept && key_cmd && i_last) begin
                    n_idx[0] = i_folded.djb[IDX_W-1:0];
                    n_idx[1] = i_folded.sdbm[IDX_W-1:0];
                    n_idx[2] = i_folded.sum[IDX_W-1:0];
                    n_check  = (cmd == CMD_CHECK);
                    n_all    = 1'b1;
                    n_k      = '0;
                end
            end
            S_READ: begin
            end
            S_UPDATE: begin
                o_mem_req.we = !r_check;
                n_all        = r_all && cur_bit;
                n_k          = r_k + K_W'(1);
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_all;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_check    <= n_check;
        r_all      <= n_all;
        r_out_data <= n_out_data;
    end

    assign o_out_valid     = r_out_valid;
    assign o_maybe_present = r_out_data;

endmodule

FILE: hw/rtl/bloom_filter_three_hash_unit.sv
// A character item is taken whenever the sequencer is idle, so the characters of a key
// stream back to back. The last item of an add key holds the input through a read
// and a write-back per hash bit; a check key holds it through the result state too,
// and it waits longer while an earlier result is still unaccepted.
// A clear item and reset sweep the store RAM one 32-bit row per cycle.
// ----------------------------------------------------------------------------
// bloom_filter_three_hash_unit
// Bloom filter keyed by streamed characters with djb2, sdbm and byte-sum hashes.
// ----------------------------------------------------------------------------
module bloom_filter_three_hash_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] command
    input  logic       s_axis_tlast,   // last character of the key
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] maybe_present, [7:1] zero
);
    import bfth_pkg::*;

    // The hash unit folds one character per accepted item. The sequencer
    // captures the folded values on the last item of a key, so the
    // accumulators restart in the same cycle and the next key can stream in
    // as soon as the store accesses are done.
    t_hash_set          folded;
    t_hash_ctrl         hash_ctrl;
    t_mem_req           mem_req;
    logic [WORD_W-1:0]  mem_rdata;
    logic               maybe_present;

    bfth_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (hash_ctrl),
        .i_char   (s_axis_tdata),
        .o_folded (folded)
    );

    // The sequencer reads a row, then writes it back or tests it in the next
    // cycle. The next read is issued only after the write has landed, so two
    // hash bits in the same row never need forwarding.
    bfth_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .o_in_ready      (s_axis_tready),
        .i_command       (s_axis_tuser),
        .i_last          (s_axis_tlast),
        .i_folded        (folded),
        .o_hash_ctrl     (hash_ctrl),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_maybe_present (maybe_present)
    );

    // The filter bits live in rows of 32 bits.
    bfth_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    assign m_axis_tdata = {7'd0, maybe_present};

    // The store is never written in a cycle in which an item is taken.
    a_no_write_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.we |-> !(s_axis_tvalid && s_axis_tready))
        else $error("store write while an item is accepted");

    // The last item of an add or check key always starts store accesses.
    a_key_end_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast
            && (s_axis_tuser == CMD_ADD || s_axis_tuser == CMD_CHECK))
        |=> !s_axis_tready)
        else $error("key end did not start the store sequence");

    // A new result only appears from the busy sequencer.
    a_result_from_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised while the sequencer was idle");

    // The hashes fold or restart only on an accepted item.
    a_hash_ctrl_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hash_ctrl.fold || hash_ctrl.restart) |-> (s_axis_tvalid && s_axis_tready))
        else $error("hash update without an accepted item");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-hash Bloom filter. A table of directed
// keys runs first, then random keys drawn partly from a pool of keys that
// were added before, so that checks hit, miss and near-miss. Every answer
// is compared with a cycle-free model of the filter kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import bfth_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int ITEM_TARGET  = 1950;
    localparam int PHASE_ITEMS  = 650;
    localparam int HOLD_CYCLES  = 600;
    // A clear sweeps ROWS rows, and an add or check key adds its store accesses.
    localparam int SETTLE_CYCLES = 2 * ROWS + 4 * NUM_HASHES + 16;
    // The slowest legal run stays far below this count of cycles.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int POOL_DEPTH   = 32;

    // How the answer of a directed row is known.
    typedef enum {
        EXP_NONE,
        EXP_MODEL,
        EXP_ZERO,
        EXP_ONE
    } t_answer;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] ch;
        logic       last;
        t_answer    want;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_byte
    logic [1:0] s_axis_tuser = 2'd0;    // [1:0] command
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [0] maybe_present, [7:1] zero

    // Model state: the three running hashes and the bit store.
    logic [31:0]            djb_hash;
    logic [31:0]            sdbm_hash;
    logic [31:0]            sum_hash;
    bit [FILTER_BITS-1:0]   filter_bits;

    // Answers the filter owes, oldest first.
    bit present_q[$];

    int  phase = 0;
    bit  rx_hold = 1'b0;
    int  cycle_count = 0;
    int  fail_count = 0;
    int  items_sent = 0;
    int  answers_seen = 0;
    int  hits_seen = 0;
    int  clears_sent = 0;
    int  adds_done = 0;

    bloom_filter_three_hash_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void restart_hashes();
        djb_hash  = DJB_START;
        sdbm_hash = 32'd0;
        sum_hash  = 32'd0;
    endfunction

    // Advances the model by one accepted item. Returns 1 when the item owes
    // an answer, which is then left in present.
    function automatic bit filter_predict(t_cmd cmd, logic [7:0] ch, logic lst,
                                          output bit present);
        logic [31:0] c;
        logic [31:0] idx;
        present = 1'b1;
        if (cmd == CMD_NONE) begin
            return 1'b0;
        end
        if (cmd == CMD_CLEAR) begin
            filter_bits = '0;
            restart_hashes();
            return 1'b0;
        end
        // A zero character leaves the hashes alone; others are sign-extended.
        if (ch != 8'h00) begin
            c = {{24{ch[7]}}, ch};
            djb_hash  = (djb_hash << 5) + djb_hash + c;
            sdbm_hash = c + (sdbm_hash << 6) + (sdbm_hash << 16) - sdbm_hash;
            sum_hash  = sum_hash + c;
        end
        if (!lst) begin
            return 1'b0;
        end
        for (int k = 0; k < NUM_HASHES; k++) begin
            idx = (k == 0) ? djb_hash : (k == 1) ? sdbm_hash : sum_hash;
            idx = idx % 32'(FILTER_BITS);
            if (cmd == CMD_ADD) begin
                filter_bits[idx] = 1'b1;
            end else if (!filter_bits[idx]) begin
                present = 1'b0;
            end
        end
        restart_hashes();
        return (cmd == CMD_CHECK);
    endfunction

    // Offers one item, waits for the handshake, then updates the model and
    // queues the answer the item owes, if any.
    task automatic send_item(t_cmd cmd, logic [7:0] ch, logic lst, t_answer want);
        int  idle_pct;
        bit  owes;
        bit  present;
        idle_pct = (phase == 0) ? 35 : (phase == 1) ? 55 : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        owes = filter_predict(cmd, ch, lst, present);
        if (owes) begin
            if (want == EXP_ZERO) present = 1'b0;
            else if (want == EXP_ONE) present = 1'b1;
            present_q.push_back(present);
        end
        if (cmd == CMD_CLEAR) clears_sent++;
        if (cmd == CMD_ADD && lst) adds_done++;
        items_sent++;
    endtask

    // Result side: checks every accepted answer against the oldest one owed,
    // and picks the ready level for the next cycle from the current phase.
    always @(posedge i_clk) begin
        bit want_present;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (present_q.size() == 0) begin
                $error("answer with none owed: tdata %0h", m_axis_tdata);
                fail_count++;
            end else begin
                want_present = present_q.pop_front();
                answers_seen++;
                if (m_axis_tdata[0]) hits_seen++;
                if (m_axis_tdata[0] !== want_present) begin
                    $error("maybe_present mismatch: expected %0d, actual %0d",
                           want_present, m_axis_tdata[0]);
                    fail_count++;
                end
                if (m_axis_tdata[7:1] !== 7'd0) begin
                    $error("tdata pad mismatch: expected %0d, actual %0d",
                           7'd0, m_axis_tdata[7:1]);
                    fail_count++;
                end
            end
        end
        if (rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (phase)
                0: m_axis_tready <= ($urandom_range(99) >= 55);
                1: m_axis_tready <= ($urandom_range(99) >= 35);
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Once the sender runs without gaps, the result side holds off for a long
    // stretch, so the output stage fills and the input stalls behind it.
    initial begin
        wait (phase == 2);
        repeat (40) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_stim_row   directed_rows [25];
        logic [63:0] key_bytes;
        logic [63:0] pool_bytes[$];
        int          pool_len[$];
        int          key_len;
        int          pick;
        int          roll;
        t_cmd        key_cmd;
        t_cmd        item_cmd;

        restart_hashes();
        filter_bits = '0;

        // The empty key, a key with every sign case of the characters, the
        // same key with zero characters spliced in, a key whose last item
        // overrides the command of the items before it, an unused command in
        // the middle of a key, and a clear that empties the store.
        directed_rows = '{
            '{CMD_CHECK, 8'h00, 1'b1, EXP_ZERO},
            '{CMD_ADD,   8'h00, 1'b1, EXP_NONE},
            '{CMD_CHECK, 8'h00, 1'b1, EXP_ONE},
            '{CMD_ADD,   8'h80, 1'b0, EXP_NONE},
            '{CMD_ADD,   8'hFF, 1'b0, EXP_NONE},
            '{CMD_ADD,   8'h7F, 1'b0, EXP_NONE},
            '{CMD_ADD,   8'h01, 1'b1, EXP_NONE},
            '{CMD_CHECK, 8'h80, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'hFF, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h7F, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h01, 1'b1, EXP_ONE},
            '{CMD_CHECK, 8'h00, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h80, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h00, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'hFF, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h7F, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h01, 1'b1, EXP_ONE},
            '{CMD_CHECK, 8'h41, 1'b0, EXP_NONE},
            '{CMD_NONE,  8'h55, 1'b1, EXP_NONE},
            '{CMD_ADD,   8'h42, 1'b1, EXP_NONE},
            '{CMD_ADD,   8'h41, 1'b0, EXP_NONE},
            '{CMD_CHECK, 8'h42, 1'b1, EXP_ONE},
            '{CMD_CLEAR, 8'hAA, 1'b1, EXP_NONE},
            '{CMD_CHECK, 8'h00, 1'b1, EXP_ZERO},
            '{CMD_CHECK, 8'h55, 1'b1, EXP_MODEL}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].cmd, directed_rows[r].ch,
                      directed_rows[r].last, directed_rows[r].want);
        end

        // Random part. Most of it is whole keys, half of them taken again from
        // the pool of added keys (sometimes with one character changed); the
        // rest is clears, ignored items and stray single items.
        while (items_sent < ITEM_TARGET) begin
            phase = (items_sent < PHASE_ITEMS) ? 0 : (items_sent < 2 * PHASE_ITEMS) ? 1 : 2;
            roll = $urandom_range(99);
            if (roll < 2) begin
                send_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          EXP_MODEL);
            end else if (roll < 6) begin
                send_item(CMD_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          EXP_MODEL);
            end else if (roll < 10) begin
                send_item(t_cmd'($urandom_range(1)), 8'($urandom_range(255)),
                          1'($urandom_range(1)), EXP_MODEL);
            end else begin
                if (pool_bytes.size() > 0 && $urandom_range(1)) begin
                    pick      = $urandom_range(pool_bytes.size() - 1);
                    key_bytes = pool_bytes[pick];
                    key_len   = pool_len[pick];
                    if ($urandom_range(3) == 0) begin
                        key_bytes[8 * $urandom_range(key_len - 1) +: 8] =
                            8'($urandom_range(255));
                    end
                end else begin
                    key_len = ($urandom_range(4) == 0) ? $urandom_range(5, 8)
                                                       : $urandom_range(1, 4);
                    for (int i = 0; i < 8; i++) begin
                        key_bytes[8 * i +: 8] = ($urandom_range(9) == 0) ? 8'h00
                                                : 8'($urandom_range(1, 255));
                    end
                end
                key_cmd = ($urandom_range(99) < 45) ? CMD_ADD : CMD_CHECK;
                for (int i = 0; i < key_len; i++) begin
                    // Only the command of the last item counts.
                    item_cmd = (i == key_len - 1) ? key_cmd : t_cmd'($urandom_range(1));
                    send_item(item_cmd, key_bytes[8 * i +: 8], (i == key_len - 1),
                              EXP_MODEL);
                end
                if (key_cmd == CMD_ADD) begin
                    if (pool_bytes.size() >= POOL_DEPTH) begin
                        void'(pool_bytes.pop_front());
                        void'(pool_len.pop_front());
                    end
                    pool_bytes.push_back(key_bytes);
                    pool_len.push_back(key_len);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (present_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d keys added, %0d clears, under three idling mixes.",
                 items_sent, adds_done, clears_sent);
        $display("Checked %0d answers, %0d of them maybe-present, with %0d errors.",
                 answers_seen, hits_seen, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
